### sv/tssm_pkg.sv
`timescale 1ns / 1ps

package tssm_pkg;

  // servo angle limit and pulse scaling
  localparam int ANGLE_LIMIT = 180;
  localparam logic [9:0]  PULSE_MIN   = 10'd80;
  // 520/180 as an unsigned fixed-point value with 16 fraction bits, exact after truncation for 0..180
  localparam logic [17:0] PULSE_SCALE = 18'd189332;

  // operation codes carried in tuser
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PAD  = 1'b1;

  // pad codes
  localparam logic [3:0] PAD_UP    = 4'd1;
  localparam logic [3:0] PAD_RIGHT = 4'd2;
  localparam logic [3:0] PAD_LEFT  = 4'd8;

  // servo write masks
  localparam logic [2:0] MASK_NONE = 3'b000;
  localparam logic [2:0] MASK_PAIR = 3'b011;
  localparam logic [2:0] MASK_C    = 3'b100;
  localparam logic [2:0] MASK_ALL  = 3'b111;

  // register indexes
  localparam logic [2:0] REG_HOME_A   = 3'd0;
  localparam logic [2:0] REG_HOME_B   = 3'd1;
  localparam logic [2:0] REG_HOME_C   = 3'd2;
  localparam logic [2:0] REG_PAIR_OFF = 3'd3;
  localparam logic [2:0] REG_THIRD    = 3'd4;
  localparam logic [2:0] REG_SLEW     = 3'd5;
  localparam logic [2:0] REG_PERIOD   = 3'd6;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_C_OUT     = 3'd1,
    PH_PAIR_OUT  = 3'd2,
    PH_C_BACK    = 3'd3,
    PH_PAIR_BACK = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0]  home_a;
    logic [7:0]  home_b;
    logic [7:0]  home_c;
    logic [7:0]  pair_off;
    logic [7:0]  third_off;
    logic [7:0]  slew;
    logic [15:0] period;
  } cfg_t;

  typedef struct packed {
    logic        run;
    phase_t      phase;
    logic [7:0]  cur_a;
    logic [7:0]  cur_b;
    logic [7:0]  cur_c;
    logic [7:0]  goal_a;
    logic [7:0]  goal_b;
    logic [7:0]  goal_c;
    logic [15:0] tick;
  } seq_state_t;

  // clamp a signed intermediate to 0..ANGLE_LIMIT
  function automatic logic [7:0] clamp_ang(input logic signed [9:0] v);
    logic [7:0] r;
    if (v < 10'sd0) r = 8'd0;
    else if (v > $signed(10'(ANGLE_LIMIT))) r = 8'(ANGLE_LIMIT);
    else r = v[7:0];
    return r;
  endfunction

  // home register saturated to the limit
  function automatic logic [7:0] home_of(input logic [7:0] h);
    return (h > 8'(ANGLE_LIMIT)) ? 8'(ANGLE_LIMIT) : h;
  endfunction

  // home plus or minus an offset, clamped
  function automatic logic [7:0] offset_ang(input logic [7:0] h, input logic [7:0] off,
                                            input logic neg);
    logic signed [9:0] v;
    v = neg ? ($signed({2'b00, h}) - $signed({2'b00, off}))
            : ($signed({2'b00, h}) + $signed({2'b00, off}));
    return clamp_ang(v);
  endfunction

  // one slew step toward the goal
  function automatic logic [7:0] slew_ang(input logic [7:0] cur, input logic [7:0] goal,
                                          input logic [7:0] s);
    logic [7:0] r;
    if (cur < goal) r = offset_ang(cur, s, 1'b0);
    else if (cur > goal) r = offset_ang(cur, s, 1'b1);
    else r = cur;
    return r;
  endfunction

  // within one step of the goal
  function automatic logic near_ang(input logic [7:0] cur, input logic [7:0] goal,
                                    input logic [7:0] s);
    logic [7:0] d;
    d = (cur >= goal) ? (cur - goal) : (goal - cur);
    return d <= s;
  endfunction

  // 80 + min(a,180)*520/180, truncated
  function automatic logic [9:0] pulse_of(input logic [7:0] a);
    logic [7:0]  u;
    logic [25:0] prod;
    u = (a > 8'd180) ? 8'd180 : a;
    prod = {18'd0, u} * {8'd0, PULSE_SCALE};
    return PULSE_MIN + prod[25:16];
  endfunction

endpackage

### sv/tssm_motion.sv
`timescale 1ns / 1ps

module tssm_motion import tssm_pkg::*; (
  input  seq_state_t st,
  input  cfg_t       cfg,
  input  logic       op,
  input  logic [3:0] pad,
  output seq_state_t st_nxt,
  output logic [2:0] mask
);

  logic [7:0]  step_sz;
  logic [15:0] period;
  logic [15:0] tick_inc;
  logic [7:0]  ha, hb, hc;
  logic [7:0]  a_out, b_out, c_out, a_home, b_home, c_home;

  // effective step, period and homes
  assign step_sz  = (cfg.slew == 8'd0) ? 8'd1 : cfg.slew;
  assign period   = (cfg.period == 16'd0) ? 16'd1 : cfg.period;
  assign tick_inc = st.tick + 16'd1;
  assign ha = home_of(cfg.home_a);
  assign hb = home_of(cfg.home_b);
  assign hc = home_of(cfg.home_c);

  // candidate slews toward the out goals and toward home
  assign a_out  = slew_ang(st.cur_a, st.goal_a, step_sz);
  assign b_out  = slew_ang(st.cur_b, st.goal_b, step_sz);
  assign c_out  = slew_ang(st.cur_c, st.goal_c, step_sz);
  assign a_home = slew_ang(st.cur_a, ha, step_sz);
  assign b_home = slew_ang(st.cur_b, hb, step_sz);
  assign c_home = slew_ang(st.cur_c, hc, step_sz);

  // next state for one word
  always_comb begin
    st_nxt = st;
    mask   = MASK_NONE;
    if (op == OP_PAD) begin
      if (!st.run && (pad inside {PAD_UP, PAD_RIGHT, PAD_LEFT})) begin
        st_nxt.cur_a  = ha;
        st_nxt.cur_b  = hb;
        st_nxt.cur_c  = hc;
        st_nxt.goal_a = offset_ang(ha, cfg.pair_off, pad == PAD_LEFT);
        st_nxt.goal_b = offset_ang(hb, cfg.pair_off, pad != PAD_RIGHT);
        st_nxt.goal_c = offset_ang(hc, cfg.third_off, 1'b0);
        st_nxt.phase  = PH_C_OUT;
        st_nxt.run    = 1'b1;
        st_nxt.tick   = 16'd0;
        mask          = MASK_ALL;
      end
    end else if (st.run) begin
      if (tick_inc >= period) begin
        st_nxt.tick = 16'd0;
        case (st.phase)
          PH_C_OUT: begin
            st_nxt.cur_c = c_out;
            if (near_ang(c_out, st.goal_c, step_sz)) st_nxt.phase = PH_PAIR_OUT;
            mask = MASK_C;
          end
          PH_PAIR_OUT: begin
            st_nxt.cur_a = a_out;
            st_nxt.cur_b = b_out;
            if (near_ang(a_out, st.goal_a, step_sz) && near_ang(b_out, st.goal_b, step_sz))
              st_nxt.phase = PH_C_BACK;
            mask = MASK_PAIR;
          end
          PH_C_BACK: begin
            st_nxt.cur_c = c_home;
            if (near_ang(c_home, hc, step_sz)) st_nxt.phase = PH_PAIR_BACK;
            mask = MASK_C;
          end
          PH_PAIR_BACK: begin
            st_nxt.cur_a = a_home;
            st_nxt.cur_b = b_home;
            if (near_ang(a_home, ha, step_sz) && near_ang(b_home, hb, step_sz)) begin
              st_nxt.phase = PH_IDLE;
              st_nxt.run   = 1'b0;
            end
            mask = MASK_PAIR;
          end
          default: begin
            st_nxt.phase = PH_IDLE;
            st_nxt.run   = 1'b0;
          end
        endcase
      end else begin
        st_nxt.tick = tick_inc;
      end
    end
  end

endmodule

### sv/three_servo_preset_motion_sequencer_core.sv
`timescale 1ns / 1ps

// Three-servo preset sequencer. Each input word is a millisecond tick
// (tuser 0) or a pad press (tuser 1, code in tdata[3:0]); every word gives
// exactly one result word with the current phase, angles, pulse counts and
// the mask of servos written. One word is taken per clock: the whole update
// is a single combinational pass from the sequence registers into the result
// register, so a result appears on out_ the cycle after its word is accepted
// and the input stays open while that result waits, as long as out_tready
// drains it. Configuration writes take effect on the next clock.
module three_servo_preset_motion_sequencer_core import tssm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] pad_value, [7:4] zero
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] busy_res, [3:1] phase, [11:4] angle_a, [19:12] angle_b, [27:20] angle_c,
  // [37:28] pulse_a, [47:38] pulse_b, [57:48] pulse_c, [60:58] write_mask, [63:61] zero
  output logic [63:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  cfg_t       cfg_r;
  seq_state_t st_r, st_nxt;
  logic [2:0] mask_nxt;
  logic       accept;

  logic       out_valid_r;
  logic       out_busy_r;
  phase_t     out_phase_r;
  logic [7:0] out_ang_a_r, out_ang_b_r, out_ang_c_r;
  logic [2:0] out_mask_r;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.home_a    <= 8'd134;
      cfg_r.home_b    <= 8'd70;
      cfg_r.home_c    <= 8'd90;
      cfg_r.pair_off  <= 8'd30;
      cfg_r.third_off <= 8'd30;
      cfg_r.slew      <= 8'd2;
      cfg_r.period    <= 16'd15;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_HOME_A:   cfg_r.home_a    <= cfg_wdata[7:0];
        REG_HOME_B:   cfg_r.home_b    <= cfg_wdata[7:0];
        REG_HOME_C:   cfg_r.home_c    <= cfg_wdata[7:0];
        REG_PAIR_OFF: cfg_r.pair_off  <= cfg_wdata[7:0];
        REG_THIRD:    cfg_r.third_off <= cfg_wdata[7:0];
        REG_SLEW:     cfg_r.slew      <= cfg_wdata[7:0];
        REG_PERIOD:   cfg_r.period    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next-state logic
  tssm_motion u_motion (
    .st     (st_r),
    .cfg    (cfg_r),
    .op     (in_tuser),
    .pad    (in_tdata[3:0]),
    .st_nxt (st_nxt),
    .mask   (mask_nxt)
  );

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.run    <= 1'b0;
      st_r.phase  <= PH_IDLE;
      st_r.cur_a  <= 8'd134;
      st_r.cur_b  <= 8'd70;
      st_r.cur_c  <= 8'd90;
      st_r.goal_a <= 8'd134;
      st_r.goal_b <= 8'd70;
      st_r.goal_c <= 8'd90;
      st_r.tick   <= 16'd0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_busy_r  <= st_nxt.run;
      out_phase_r <= st_nxt.phase;
      out_ang_a_r <= st_nxt.cur_a;
      out_ang_b_r <= st_nxt.cur_b;
      out_ang_c_r <= st_nxt.cur_c;
      out_mask_r  <= mask_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_mask_r,
                       pulse_of(out_ang_c_r), pulse_of(out_ang_b_r), pulse_of(out_ang_a_r),
                       out_ang_c_r, out_ang_b_r, out_ang_a_r,
                       out_phase_r, out_busy_r};

  // run flag and phase agree
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r.run == (st_r.phase != PH_IDLE))
    else $error("run flag and phase disagree");

  // tick counter rests at zero while idle
  assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.run |-> st_r.tick == 16'd0)
    else $error("tick counter moved while idle");

  // a valid press while idle starts the sequence
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser == OP_PAD && !st_r.run &&
     (in_tdata[3:0] == PAD_UP || in_tdata[3:0] == PAD_RIGHT || in_tdata[3:0] == PAD_LEFT))
    |=> (out_mask_r == MASK_ALL && st_r.phase == PH_C_OUT))
    else $error("preset start missed");

  // a tick never writes all three servos
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser == OP_TICK) |=> out_mask_r != MASK_ALL)
    else $error("tick reported a full write");

endmodule

### tb/servo_word_checker.sv
`timescale 1ns / 1ps

// watches both streams and the register port, keeps its own copy of the
// sequencer state and checks every result word against the predicted one
module servo_word_checker import tssm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          mismatches,
  output int          in_flight,
  output int          preset_starts
);

  localparam int PULSE_BASE  = 80;
  localparam int PULSE_RANGE = 520;
  localparam int SERVO_RANGE = 180;
  localparam int NUM_FIELDS  = 9;
  localparam int REPORT_MAX  = 10;

  // result word, lowest field last
  typedef struct packed {
    logic [2:0] unused_bits;
    logic [2:0] mask;
    logic [9:0] pulse_c;
    logic [9:0] pulse_b;
    logic [9:0] pulse_a;
    logic [7:0] angle_c;
    logic [7:0] angle_b;
    logic [7:0] angle_a;
    logic [2:0] phase;
    logic       busy;
  } servo_word_t;

  string field_names [NUM_FIELDS] = '{"busy_res", "phase", "angle_a", "angle_b", "angle_c",
                                      "pulse_a", "pulse_b", "pulse_c", "write_mask"};

  // mirrored registers
  logic [7:0]  home_a, home_b, home_c;
  logic [7:0]  pair_off, third_off, slew_cfg;
  logic [15:0] period_cfg;

  // mirrored sequence state
  bit          running;
  phase_t      seq_ph;
  int          ang_a, ang_b, ang_c;
  int          goal_a, goal_b, goal_c;
  int unsigned ticks;

  servo_word_t expected_words [$];
  int          bad_words;
  int          starts_seen;
  int          results_seen;

  function automatic int clip_deg(int v);
    if (v < 0) return 0;
    if (v > ANGLE_LIMIT) return ANGLE_LIMIT;
    return v;
  endfunction

  // a zero step still moves one degree
  function automatic int stride();
    return (slew_cfg == 8'd0) ? 1 : int'(slew_cfg);
  endfunction

  function automatic int step_toward(int cur, int tgt);
    int s;
    s = stride();
    if (cur < tgt) cur += s;
    else if (cur > tgt) cur -= s;
    return clip_deg(cur);
  endfunction

  function automatic bit arrived(int cur, int tgt);
    int d;
    d = cur - tgt;
    if (d < 0) d = -d;
    return d <= stride();
  endfunction

  function automatic logic [9:0] pulse_count(int a);
    int u;
    u = (a > SERVO_RANGE) ? SERVO_RANGE : a;
    return 10'(PULSE_BASE + u * PULSE_RANGE / SERVO_RANGE);
  endfunction

  // one motion step of the current phase, homes read fresh each time
  function automatic logic [2:0] advance_phase();
    int ha, hb, hc;
    ha = clip_deg(int'(home_a));
    hb = clip_deg(int'(home_b));
    hc = clip_deg(int'(home_c));
    case (seq_ph)
      PH_C_OUT: begin
        ang_c = step_toward(ang_c, goal_c);
        if (arrived(ang_c, goal_c)) seq_ph = PH_PAIR_OUT;
        return MASK_C;
      end
      PH_PAIR_OUT: begin
        ang_a = step_toward(ang_a, goal_a);
        ang_b = step_toward(ang_b, goal_b);
        if (arrived(ang_a, goal_a) && arrived(ang_b, goal_b)) seq_ph = PH_C_BACK;
        return MASK_PAIR;
      end
      PH_C_BACK: begin
        ang_c = step_toward(ang_c, hc);
        if (arrived(ang_c, hc)) seq_ph = PH_PAIR_BACK;
        return MASK_C;
      end
      PH_PAIR_BACK: begin
        ang_a = step_toward(ang_a, ha);
        ang_b = step_toward(ang_b, hb);
        if (arrived(ang_a, ha) && arrived(ang_b, hb)) begin
          seq_ph = PH_IDLE;
          running = 1'b0;
        end
        return MASK_PAIR;
      end
      default: begin
        seq_ph = PH_IDLE;
        running = 1'b0;
        return MASK_NONE;
      end
    endcase
  endfunction

  // pad press: only up, right and left start a preset, and only when idle
  function automatic logic [2:0] start_preset(logic [3:0] pad);
    int off, da, db;
    off = int'(pair_off);
    if (running) return MASK_NONE;
    case (pad)
      PAD_UP: begin
        da = off;
        db = -off;
      end
      PAD_RIGHT: begin
        da = off;
        db = off;
      end
      PAD_LEFT: begin
        da = -off;
        db = -off;
      end
      default: return MASK_NONE;
    endcase
    ang_a = clip_deg(int'(home_a));
    ang_b = clip_deg(int'(home_b));
    ang_c = clip_deg(int'(home_c));
    goal_a = clip_deg(ang_a + da);
    goal_b = clip_deg(ang_b + db);
    goal_c = clip_deg(ang_c + int'(third_off));
    seq_ph = PH_C_OUT;
    running = 1'b1;
    ticks = 0;
    return MASK_ALL;
  endfunction

  // next result word for one accepted input word
  function automatic servo_word_t predict_word(logic op, logic [3:0] pad);
    servo_word_t w;
    logic [2:0]  m;
    int unsigned per;
    m = MASK_NONE;
    per = (period_cfg == 16'd0) ? 1 : int'(period_cfg);
    if (op == OP_PAD) begin
      m = start_preset(pad);
    end else if (running) begin
      ticks = (ticks + 1) & 32'h0000_FFFF;
      if (ticks >= per) begin
        ticks = 0;
        m = advance_phase();
      end
    end
    w = '0;
    w.busy    = running;
    w.phase   = seq_ph;
    w.angle_a = 8'(ang_a);
    w.angle_b = 8'(ang_b);
    w.angle_c = 8'(ang_c);
    w.pulse_a = pulse_count(ang_a);
    w.pulse_b = pulse_count(ang_b);
    w.pulse_c = pulse_count(ang_c);
    w.mask    = m;
    return w;
  endfunction

  function automatic int field_of(servo_word_t w, int k);
    case (k)
      0: return int'(w.busy);
      1: return int'(w.phase);
      2: return int'(w.angle_a);
      3: return int'(w.angle_b);
      4: return int'(w.angle_c);
      5: return int'(w.pulse_a);
      6: return int'(w.pulse_b);
      7: return int'(w.pulse_c);
      default: return int'(w.mask);
    endcase
  endfunction

  // compare results first, then predict new words, then take register writes
  always @(posedge clk) begin : watch
    servo_word_t want;
    servo_word_t got;
    bit          bad;
    if (!rst_n) begin
      home_a = 8'd134;
      home_b = 8'd70;
      home_c = 8'd90;
      pair_off = 8'd30;
      third_off = 8'd30;
      slew_cfg = 8'd2;
      period_cfg = 16'd15;
      running = 1'b0;
      seq_ph = PH_IDLE;
      ang_a = 134;
      ang_b = 70;
      ang_c = 90;
      goal_a = 134;
      goal_b = 70;
      goal_c = 90;
      ticks = 0;
      expected_words.delete();
      bad_words = 0;
      starts_seen = 0;
      results_seen = 0;
    end else begin
      // result side
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        results_seen++;
        if (expected_words.size() == 0) begin
          if (bad_words < REPORT_MAX)
            $display("unexpected result word %0d: %h", results_seen, out_tdata);
          bad_words++;
        end else begin
          want = expected_words.pop_front();
          bad = 1'b0;
          for (int k = 0; k < NUM_FIELDS; k++) begin
            if (field_of(want, k) != field_of(got, k)) begin
              if (bad_words < REPORT_MAX)
                $display("result word %0d: %s expected %0d got %0d", results_seen,
                         field_names[k], field_of(want, k), field_of(got, k));
              bad = 1'b1;
            end
          end
          if (bad) bad_words++;
        end
      end
      // input side
      if (in_tvalid && in_tready) begin
        want = predict_word(in_tuser, in_tdata[3:0]);
        if (want.mask == MASK_ALL) starts_seen++;
        expected_words.push_back(want);
      end
      // register writes take effect for the next word
      if (cfg_we) begin
        case (cfg_addr)
          REG_HOME_A:   home_a = cfg_wdata[7:0];
          REG_HOME_B:   home_b = cfg_wdata[7:0];
          REG_HOME_C:   home_c = cfg_wdata[7:0];
          REG_PAIR_OFF: pair_off = cfg_wdata[7:0];
          REG_THIRD:    third_off = cfg_wdata[7:0];
          REG_SLEW:     slew_cfg = cfg_wdata[7:0];
          REG_PERIOD:   period_cfg = cfg_wdata;
          default: ;
        endcase
      end
    end
    mismatches <= bad_words;
    in_flight <= expected_words.size();
    preset_starts <= starts_seen;
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tssm_pkg::*;

  localparam int CHUNKS      = 15;
  localparam int CHUNK_WORDS = 110;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tuser = OP_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = REG_HOME_A;
  logic [15:0] cfg_wdata = 16'd0;

  int mismatches;
  int in_flight;
  int preset_starts;
  int words_sent = 0;
  int settings_used = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;

  three_servo_preset_motion_sequencer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [3:0] pad_value, [7:4] zero
    .in_tuser   (in_tuser),   // [0] operation
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // busy, phase, angles a..c, pulses a..c, write_mask
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  servo_word_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .in_flight     (in_flight),
    .preset_starts (preset_starts)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // offer one word and wait for it to be taken
  task automatic send_word(logic op, logic [3:0] pad);
    // idle cycles drawn one cycle at a time
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {4'd0, pad};
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(logic [15:0] ha, logic [15:0] hb, logic [15:0] hc,
                              logic [15:0] po, logic [15:0] tof, logic [15:0] sl,
                              logic [15:0] per);
    write_reg(REG_HOME_A, ha);
    write_reg(REG_HOME_B, hb);
    write_reg(REG_HOME_C, hc);
    write_reg(REG_PAIR_OFF, po);
    write_reg(REG_THIRD, tof);
    write_reg(REG_SLEW, sl);
    write_reg(REG_PERIOD, per);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // angles and offsets lean toward the edges, some above the limit
  function automatic logic [15:0] rand_angle();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'd180;
    if (r == 2) return 16'($urandom_range(255, 181));
    return 16'($urandom_range(180));
  endfunction

  function automatic logic [15:0] rand_slew();
    int r;
    r = $urandom_range(11);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'd180;
    if (r == 2) return 16'd255;
    return 16'($urandom_range(12, 1));
  endfunction

  initial begin
    logic       op;
    logic [3:0] pad;
    int         r;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes: home above limit and zero, zero step and zero period
    program_regs(16'd255, 16'd0, 16'd180, 16'd180, 16'd0, 16'd0, 16'd0);
    send_word(OP_TICK, 4'd0);
    send_word(OP_PAD, 4'd0);
    send_word(OP_PAD, 4'd15);
    send_word(OP_PAD, 4'd4);
    send_word(OP_PAD, PAD_UP);
    send_word(OP_PAD, PAD_RIGHT);
    repeat (5) send_word(OP_TICK, 4'd0);
    drain_results();

    // full-range step with a short period
    program_regs(16'd0, 16'd180, 16'd0, 16'd90, 16'd180, 16'd180, 16'd2);
    send_word(OP_PAD, PAD_RIGHT);
    repeat (9) send_word(OP_TICK, 4'd0);
    drain_results();

    // longest period, then shortened while a sequence runs
    program_regs(16'd134, 16'd70, 16'd90, 16'd30, 16'd30, 16'd2, 16'd65535);
    send_word(OP_PAD, PAD_LEFT);
    send_word(OP_TICK, 4'd0);
    send_word(OP_TICK, 4'd0);
    drain_results();
    write_reg(REG_PERIOD, 16'd1);
    cfg_we <= 1'b0;
    repeat (3) send_word(OP_TICK, 4'd0);
    drain_results();

    // random part: mostly ticks, presses now and then
    for (int c = 0; c < CHUNKS; c++) begin
      if (c < 5) begin
        send_idle = 38;
        recv_idle <= 63;
      end else if (c < 10) begin
        send_idle = 63;
        recv_idle <= 38;
      end else begin
        send_idle = 0;
        recv_idle <= 0;
      end
      if (c == 10) hold_go <= 1'b1;
      program_regs(rand_angle(), rand_angle(), rand_angle(), rand_angle(), rand_angle(),
                   rand_slew(), ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(4, 1)));
      repeat (CHUNK_WORDS) begin
        pad = 4'($urandom_range(15));
        op = OP_TICK;
        if ($urandom_range(99) < 12) begin
          op = OP_PAD;
          r = $urandom_range(9);
          if (r < 3) pad = PAD_UP;
          else if (r < 6) pad = PAD_RIGHT;
          else if (r < 8) pad = PAD_LEFT;
        end
        send_word(op, pad);
      end
      drain_results();
    end

    repeat (6) @(posedge clk);
    $display("covered %0d words with %0d preset starts over %0d register settings",
             words_sent, preset_starts, settings_used);
    if (mismatches == 0 && in_flight == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
